FILE: design/fdd_pkg.sv
`default_nettype none
package fdd_pkg;

   // command codes
   localparam logic [1:0] CMD_PAIR   = 2'd0;
   localparam logic [1:0] CMD_INT    = 2'd1;
   localparam logic [1:0] CMD_SCALED = 2'd2;

   // symbol code for the minus sign
   localparam logic [3:0] SYM_MINUS = 4'd10;

   // number range limits on the magnitude
   localparam logic [19:0] NEG_MAX_MAG = 20'd999;
   localparam logic [19:0] POS_MAX_MAG = 20'd9999;
   localparam logic [19:0] DIV_MIN_MAG = 20'd10;

   // reciprocal of ten in 16 fraction bits, exact for magnitudes up to 9999
   localparam logic [12:0] RECIP_TEN = 13'd6554;
   localparam int          RECIP_SHIFT = 16;

   localparam int MAG_W = 14;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         device;
      logic               line;
      logic [6:0]         left_pair;
      logic [6:0]         right_pair;
      logic signed [19:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] target_device;
      logic [2:0] position;
      logic [3:0] symbol;
      logic       decimal_point;
      logic       last;
   } rsp_type;

   // classified command waiting for the digit sequencer
   typedef struct packed {
      logic [2:0]       device;
      logic             line;
      logic             neg;
      logic             div10;
      logic [MAG_W-1:0] mag;
      logic [3:0]       dp_mask;
   } job_type;

   // weight of a display column: 1000, 100, 10, 1
   function automatic logic [MAG_W-1:0] place_weight(input logic [1:0] col);
      logic [MAG_W-1:0] w;
      begin
         unique case (col)
            2'd3: w = 14'd1000;
            2'd2: w = 14'd100;
            2'd1: w = 14'd10;
            default: w = 14'd1;
         endcase
         return w;
      end
   endfunction

endpackage
`default_nettype wire

FILE: design/fdd_front.sv
`default_nettype none
module fdd_front (
   input  fdd_pkg::req_type req_i,
   input  logic             show_dot_i,
   output logic             keep_o,
   output fdd_pkg::job_type job_o
);
   import fdd_pkg::*;

   logic        is_neg;
   logic [19:0] mag20;
   logic [6:0]  lp_mod;
   logic [6:0]  rp_mod;
   logic [MAG_W-1:0] pair_val;

   always_comb begin
      is_neg = req_i.value[19];
      mag20  = is_neg ? (~req_i.value + 20'd1) : req_i.value;

      // pairs above 99 drop their hundreds
      lp_mod = (req_i.left_pair  >= 7'd100) ? (req_i.left_pair  - 7'd100) : req_i.left_pair;
      rp_mod = (req_i.right_pair >= 7'd100) ? (req_i.right_pair - 7'd100) : req_i.right_pair;
      pair_val = ({7'd0, lp_mod} << 6) + ({7'd0, lp_mod} << 5) + ({7'd0, lp_mod} << 2)
               + {7'd0, rp_mod};

      keep_o         = 1'b0;
      job_o.device   = req_i.device;
      job_o.line     = req_i.line;
      job_o.neg      = 1'b0;
      job_o.div10    = 1'b0;
      job_o.mag      = mag20[MAG_W-1:0];
      job_o.dp_mask  = {1'b0, show_dot_i, 2'b00};

      unique case (req_i.command)
         CMD_PAIR: begin
            keep_o        = 1'b1;
            job_o.mag     = pair_val;
            job_o.dp_mask = 4'b0100;
         end
         CMD_INT: begin
            keep_o    = is_neg ? (mag20 <= NEG_MAX_MAG) : (mag20 <= POS_MAX_MAG);
            job_o.neg = is_neg;
            if (is_neg) begin
               job_o.dp_mask = {2'b00, show_dot_i, 1'b0};
            end
         end
         CMD_SCALED: begin
            keep_o = (mag20 <= POS_MAX_MAG);
            if (is_neg) begin
               if (mag20 >= DIV_MIN_MAG) begin
                  job_o.neg     = 1'b1;
                  job_o.div10   = 1'b1;
                  job_o.dp_mask = {2'b00, show_dot_i, 1'b0};
               end else begin
                  // rounds toward zero to a plain zero
                  job_o.mag = '0;
               end
            end
         end
         default: begin
            keep_o = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/fdd_queue.sv
`default_nettype none
module fdd_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   output logic             full_o,
   input  fdd_pkg::job_type data_i,
   input  logic             pop_i,
   output logic             empty_o,
   output fdd_pkg::job_type data_o
);
   import fdd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign data_o  = mem_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

endmodule
`default_nettype wire

FILE: design/fdd_back.sv
`default_nettype none
module fdd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty_i,
   input  fdd_pkg::job_type job_i,
   output logic             job_pop_o,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fdd_pkg::rsp_type rsp_data
);
   import fdd_pkg::*;

   logic             busy_ff, busy_in;
   logic [1:0]       col_ff, col_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   job_type          job_ff, job_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             advance, finishing, load;
   logic [3:0]       digit;
   logic [MAG_W-1:0] sub;
   logic [MAG_W-1:0] multiple;
   logic [MAG_W+12:0] prod;
   logic [MAG_W-1:0] load_mag;

   // one digit per cycle unless stalled, top digit first, by compare to nine multiples
   always_comb begin
      digit = 4'd0;
      sub   = '0;
      for (int k = 1; k <= 9; k++) begin
         multiple = MAG_W'(place_weight(col_ff) * k);
         if (rem_ff >= multiple) begin
            digit = 4'(k);
            sub   = multiple;
         end
      end
   end

   assign prod     = job_i.mag * RECIP_TEN;
   assign load_mag = job_i.div10 ? MAG_W'(prod >> RECIP_SHIFT) : job_i.mag;

   assign advance   = busy_ff && (!out_valid_ff || rsp_pop);
   assign finishing = advance && (col_ff == 2'd0);
   assign load      = !job_empty_i && (!busy_ff || finishing);
   assign job_pop_o = load;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      busy_in      = busy_ff;
      col_in       = col_ff;
      rem_in       = rem_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in         = 1'b1;
         out_in.target_device = job_ff.device;
         out_in.position      = {job_ff.line, col_ff};
         out_in.symbol        = (col_ff == 2'd3 && job_ff.neg) ? SYM_MINUS : digit;
         out_in.decimal_point = job_ff.dp_mask[col_ff];
         out_in.last          = (col_ff == 2'd0);
         col_in               = col_ff - 2'd1;
         rem_in               = rem_ff - sub;
      end
      if (finishing) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         col_in  = 2'd3;
         rem_in  = load_mag;
         job_in  = job_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      rem_ff <= rem_in;
      job_ff <= job_in;
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

FILE: design/four_digit_display_formatter.sv
`default_nettype none
// four digit display formatter: each accepted command word turns into four digit
// words for one row of a seven-segment chip, columns 3 down to 0, the fourth with
// last set. command 0 shows two pairs with a dot after the left pair, command 1 an
// integer in -999..9999 (minus sign and three digits when negative), command 2 a
// hundredths value where negatives are divided by ten toward zero. out-of-range
// values and command 3 are taken and produce no words. the digit sequencer emits
// one column per cycle while the result register can take it, and loads the next
// command as it finishes the last column. a short queue lets new commands enter
// while the sequencer works, and the result register lets the sequencer run ahead
// of pop by one word. show_dot is written through the csr channel, always ready
module four_digit_display_formatter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   // command words
   input  logic             req_push,
   output logic             req_full,
   input  fdd_pkg::req_type req_data,
   // digit words
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fdd_pkg::rsp_type rsp_data,
   // show_dot register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import fdd_pkg::*;

   logic    show_dot_ff, show_dot_in;
   logic    keep;
   job_type front_job;
   job_type q_job;
   logic    q_full, q_empty, q_pop;

   // config register, single bit, no index
   assign csr_ready   = 1'b1;
   assign show_dot_in = (csr_valid && csr_ready) ? csr_data : show_dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         show_dot_ff <= 1'b0;
      end else begin
         show_dot_ff <= show_dot_in;
      end
   end

   // front: range check, sign handling, pair packing
   fdd_front u_front (
      .req_i      (req_data),
      .show_dot_i (show_dot_ff),
      .keep_o     (keep),
      .job_o      (front_job)
   );

   // dropped commands are still taken while the queue is not full, they just never reach the queue
   assign req_full = q_full;

   fdd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (req_push && keep),
      .full_o  (q_full),
      .data_i  (front_job),
      .pop_i   (q_pop),
      .empty_o (q_empty),
      .data_o  (q_job)
   );

   // back: digit sequencer and result register
   fdd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty_i (q_empty),
      .job_i       (q_job),
      .job_pop_o   (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   // last marks column 0 and nothing else
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last == (rsp_data.position[1:0] == 2'd0)))
      else $error("last flag on wrong column");

   // minus sign only in the leftmost column
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.symbol == SYM_MINUS) |-> (rsp_data.position[1:0] == 2'd3))
      else $error("minus sign outside leftmost column");

   // no symbol code beyond the minus sign
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.symbol <= SYM_MINUS))
      else $error("symbol code out of range");

   // a popped word that is not last is followed by the next column of the same row
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=>
         (rsp_empty || rsp_data.position == $past(rsp_data.position) - 3'd1))
      else $error("column order broken");

endmodule
`default_nettype wire
